/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define LSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define LSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/lse_pkg.sv */
// Shared types and constants of the LSB steganography embed and extract block.
package lse_pkg;

  // Field and state widths.
  localparam int BYTE_W = 8;
  localparam int LEN_W = 20;
  localparam int PIX_W = 28;
  localparam int IDX_W = 24;
  localparam int PHASE_W = 3;
  localparam int HEADER_BITS_DEF = 20;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 28;
  localparam logic [CFG_ADDR_W-1:0] CFG_EMBED_MODE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MESSAGE_LENGTH = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_PIXELS = 2'd2;

  // Low bit masks for the red byte.
  localparam logic [BYTE_W-1:0] LSB_SET = 8'b00000001;
  localparam logic [BYTE_W-1:0] LSB_CLEAR = 8'b11111110;

  typedef struct packed {
    logic             embed_mode;
    logic [LEN_W-1:0] message_length;
    logic [PIX_W-1:0] image_pixels;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_red;
    logic [BYTE_W-1:0] message_char;
    logic              first_pixel;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_out;
    logic [BYTE_W-1:0] char_out;
    logic              char_valid;
    logic              length_valid;
    logic [LEN_W-1:0]  found_length;
    logic              message_done;
    logic              status;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   pixel_index;
    logic [LEN_W-1:0]   header_value;
    logic [LEN_W-1:0]   chars_remaining;
    logic [PHASE_W-1:0] bit_phase;
    logic [BYTE_W-1:0]  char_accum;
    logic               finished;
  } state_t;

endpackage

/* rtl/lse_cfg_if.sv */
// Configuration write channel interface.
interface lse_cfg_if import lse_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

/* rtl/lse_in_if.sv */
// Pixel input channel interface.
interface lse_in_if import lse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_red;
  logic [BYTE_W-1:0] message_char;
  logic              first_pixel;

  modport source (output valid, output pixel_red, output message_char, output first_pixel,
                  input ready);
  modport sink (input valid, input pixel_red, input message_char, input first_pixel,
                output ready);
endinterface

/* rtl/lse_out_if.sv */
// Result channel interface.
interface lse_out_if import lse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_out;
  logic [BYTE_W-1:0] char_out;
  logic              char_valid;
  logic              length_valid;
  logic [LEN_W-1:0]  found_length;
  logic              message_done;
  logic              status;

  modport source (output valid, output pixel_out, output char_out, output char_valid,
                  output length_valid, output found_length, output message_done,
                  output status, input ready);
  modport sink (input valid, input pixel_out, input char_out, input char_valid,
                input length_valid, input found_length, input message_done,
                input status, output ready);
endinterface

/* rtl/lse_cfg_regs.sv */
// Configuration registers written through the configuration channel.
module lse_cfg_regs import lse_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  lse_cfg_if.sink cfg_if,
  output cfg_t   cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always taken.
  assign cfg_if.ready = 1'b1;

  // Decode the register index; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.addr)
        CFG_EMBED_MODE:     cfg_nxt.embed_mode = cfg_if.data[0];
        CFG_MESSAGE_LENGTH: cfg_nxt.message_length = cfg_if.data[LEN_W-1:0];
        CFG_IMAGE_PIXELS:   cfg_nxt.image_pixels = cfg_if.data[PIX_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/lse_step.sv */
// Per-pixel embed or extract logic with the header and character counters.
module lse_step import lse_pkg::*; #(
  parameter int HEADER_BITS = HEADER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_item_t  item,
  input  logic      advance,
  output out_item_t res
);

  localparam int NEED_W = LEN_W + 3 + 11;

  state_t            state_r;
  state_t            state_nxt;
  state_t            cur;
  logic              in_image;
  logic              in_hdr;
  logic              hdr_last;
  logic [31:0]       sh_amt;
  logic [LEN_W-1:0]  hdr_shift;
  logic [IDX_W-1:0]  idx_inc;
  logic [PHASE_W-1:0] phase_inc;
  logic              char_end;
  logic [LEN_W-1:0]  rem_dec;
  logic [NEED_W-1:0] need;
  logic              embed_err;
  logic              bit_in;
  logic              bit_emb;
  logic [LEN_W-1:0]  hdr_new;
  logic [BYTE_W-1:0] acc_new;

  // A first pixel sees cleared counters.
  assign cur = item.first_pixel ? '0 : state_r;

  // Position of this pixel within the image and the header.
  assign in_image = PIX_W'(cur.pixel_index) < cfg.image_pixels;
  assign in_hdr = 32'(cur.pixel_index) < 32'(HEADER_BITS);
  assign hdr_last = 32'(cur.pixel_index) == 32'(HEADER_BITS - 1);
  assign sh_amt = 32'(HEADER_BITS - 1) - 32'(cur.pixel_index);
  assign hdr_shift = cfg.message_length >> sh_amt;
  assign idx_inc = (cur.pixel_index == '1) ? cur.pixel_index : cur.pixel_index + 1'b1;
  assign phase_inc = cur.bit_phase + 1'b1;
  assign char_end = (cur.bit_phase == '1);
  assign rem_dec = cur.chars_remaining - 1'b1;

  // Capacity check for embedding.
  assign need = {11'b0, cfg.message_length, 3'b000} + NEED_W'(HEADER_BITS);
  assign embed_err = (cfg.image_pixels == '0) ||
                     (need > NEED_W'(cfg.image_pixels)) ||
                     ((cfg.message_length >> HEADER_BITS) != '0);

  assign bit_in = item.pixel_red[0];
  assign bit_emb = item.message_char[3'd7 - cur.bit_phase];
  assign hdr_new = {cur.header_value[LEN_W-2:0], bit_in};
  assign acc_new = {cur.char_accum[BYTE_W-2:0], bit_in};

  // Next state and result for one pixel.
  always_comb begin
    state_nxt = cur;
    res = '0;
    res.pixel_out = item.pixel_red;
    if (cfg.embed_mode) begin
      if (embed_err) begin
        res.status = 1'b1;
        state_nxt.pixel_index = idx_inc;
      end else begin
        if (in_image && !cur.finished) begin
          if (in_hdr) begin
            res.pixel_out = (item.pixel_red & LSB_CLEAR) | (hdr_shift[0] ? LSB_SET : '0);
            if (hdr_last) begin
              state_nxt.chars_remaining = cfg.message_length;
              state_nxt.bit_phase = '0;
              if (cfg.message_length == '0) begin
                state_nxt.finished = 1'b1;
              end
            end
          end else if (cur.chars_remaining != '0) begin
            res.pixel_out = (item.pixel_red & LSB_CLEAR) | (bit_emb ? LSB_SET : '0);
            state_nxt.bit_phase = phase_inc;
            if (char_end) begin
              state_nxt.chars_remaining = rem_dec;
              if (rem_dec == '0) begin
                state_nxt.finished = 1'b1;
              end
            end
          end else begin
            state_nxt.finished = 1'b1;
          end
        end
        state_nxt.pixel_index = idx_inc;
        res.message_done = state_nxt.finished;
      end
    end else begin
      if (cfg.image_pixels == '0) begin
        res.status = 1'b1;
      end else if (in_image && !cur.finished) begin
        if (in_hdr) begin
          state_nxt.header_value = hdr_new;
          if (hdr_last) begin
            res.length_valid = 1'b1;
            state_nxt.chars_remaining = hdr_new;
            state_nxt.bit_phase = '0;
            state_nxt.char_accum = '0;
            if (hdr_new == '0) begin
              state_nxt.finished = 1'b1;
            end
          end
        end else if (cur.chars_remaining != '0) begin
          state_nxt.char_accum = acc_new;
          state_nxt.bit_phase = phase_inc;
          if (char_end) begin
            res.char_out = acc_new;
            res.char_valid = 1'b1;
            state_nxt.char_accum = '0;
            state_nxt.chars_remaining = rem_dec;
            if (rem_dec == '0) begin
              state_nxt.finished = 1'b1;
            end
          end
        end else begin
          state_nxt.finished = 1'b1;
        end
      end
      state_nxt.pixel_index = idx_inc;
      res.found_length = state_nxt.header_value;
      res.message_done = state_nxt.finished;
    end
  end

  // Counters move only when the item goes to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/lsb_stego_embed_extract.sv */
// LSB steganography embed and extract block, top level.
// An accepted pixel is held in the input register and then in the result register, which offers it.
// Throughput: one pixel per cycle; once the input and result registers both hold an
// item, a stalled receiver also stalls the input.
// Reset (rst_n low, synchronous) clears the configuration registers, the counters and both
// pipeline valid flags; no clearing pass is needed.
module lsb_stego_embed_extract import lse_pkg::*; #(
  parameter int HEADER_BITS = HEADER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lse_cfg_if.sink   cfg_if,
  lse_in_if.sink    in_if,
  lse_out_if.source out_if
);

  cfg_t      cfg;
  in_item_t  in_item_r;
  in_item_t  in_item_nxt;
  logic      in_valid_r;
  logic      in_valid_nxt;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t res;
  logic      advance;
  logic      in_take;

  lse_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  lse_step #(
    .HEADER_BITS (HEADER_BITS)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (in_item_r),
    .advance (advance),
    .res     (res)
  );

  // Handshake: the held item moves on whenever the result register is free.
  assign advance = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;
  assign in_take = in_if.valid && in_if.ready;

  // Input register.
  always_comb begin
    in_item_nxt = in_item_r;
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_item_nxt.pixel_red = in_if.pixel_red;
      in_item_nxt.message_char = in_if.message_char;
      in_item_nxt.first_pixel = in_if.first_pixel;
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  // Result register.
  always_comb begin
    out_item_nxt = out_item_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_item_nxt = res;
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.pixel_out = out_item_r.pixel_out;
  assign out_if.char_out = out_item_r.char_out;
  assign out_if.char_valid = out_item_r.char_valid;
  assign out_if.length_valid = out_item_r.length_valid;
  assign out_if.found_length = out_item_r.found_length;
  assign out_if.message_done = out_item_r.message_done;
  assign out_if.status = out_item_r.status;

endmodule

/* rtl/lse_checker.sv */
// Port-level assertions for the steganography block and their bind.
`include "assert_macros.svh"

module lse_checker import lse_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_pixel_out,
  input logic [BYTE_W-1:0] out_char_out,
  input logic              out_char_valid,
  input logic              out_length_valid
);

  logic out_stall;
  logic no_char;
  logic both_done;

  // Shorthands for the conditions below.
  assign out_stall = out_valid && !out_ready;
  assign no_char = out_valid && !out_char_valid;
  assign both_done = out_char_valid && out_length_valid;

  // A stalled result stays offered.
  `LSE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid, "result dropped in stall")

  // A stalled result keeps its pixel.
  `LSE_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(out_pixel_out), "pixel moved")

  // Input backpressure only comes from a stalled result.
  `LSE_ASSERT(a_in_stall, clk, rst_n, !in_ready |-> out_stall, "input stalled on its own")

  // A character is reported only on its own, never with the header, and is zero otherwise.
  `LSE_ASSERT(a_char_zero, clk, rst_n, no_char |-> (out_char_out == '0), "stray char_out")
  `LSE_ASSERT(a_char_len, clk, rst_n, out_valid |-> !both_done, "char with length")

endmodule

bind lsb_stego_embed_extract lse_checker u_lse_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_pixel_out    (out_if.pixel_out),
  .out_char_out     (out_if.char_out),
  .out_char_valid   (out_if.char_valid),
  .out_length_valid (out_if.length_valid)
);

/* verif/tb_lsb_stego_embed_extract.sv */
// Self-checking testbench of the LSB steganography embed and extract block.
module tb_lsb_stego_embed_extract;
  import lse_pkg::*;

  localparam int HDR          = HEADER_BITS_DEF;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_ITEMS = 750;

  // Predicts the result of every accepted pixel and checks results in order.
  class pixel_scoreboard;
    cfg_t      regs;
    state_t    st;
    out_item_t expected_q[$];
    int        fails;
    int        result_count;

    function new();
      regs = '0;
      st = '0;
      fails = 0;
      result_count = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      fails++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    // Mirror a register write as the block applies it.
    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_EMBED_MODE:     regs.embed_mode = data[0];
        CFG_MESSAGE_LENGTH: regs.message_length = data[LEN_W-1:0];
        CFG_IMAGE_PIXELS:   regs.image_pixels = data[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    function void bump_index();
      if (st.pixel_index != '1) st.pixel_index++;
    endfunction

    // Work out the result of one accepted pixel and advance the state.
    function void note_pixel(in_item_t it);
      out_item_t   r;
      logic        in_img;
      logic        b;
      logic [31:0] need;
      int          pos;
      r = '0;
      r.pixel_out = it.pixel_red;
      if (it.first_pixel) st = '0;
      in_img = {4'b0, st.pixel_index} < regs.image_pixels;
      if (regs.embed_mode) begin
        need = {9'b0, regs.message_length, 3'b000} + 32'(HDR);
        if (regs.image_pixels == 0 || need > {4'b0, regs.image_pixels} ||
            (regs.message_length >> HDR) != 0) begin
          // Empty or too small image: pass through, only the index moves.
          r.status = 1'b1;
          bump_index();
          expected_q.push_back(r);
          return;
        end
        if (in_img && !st.finished) begin
          if (st.pixel_index < HDR) begin
            pos = HDR - 1 - int'(st.pixel_index);
            b = (pos < LEN_W) ? regs.message_length[pos] : 1'b0;
            r.pixel_out = (it.pixel_red & LSB_CLEAR) | (b ? LSB_SET : 8'h00);
            if (st.pixel_index == HDR - 1) begin
              st.chars_remaining = regs.message_length;
              st.bit_phase = '0;
              if (st.chars_remaining == 0) st.finished = 1'b1;
            end
          end else if (st.chars_remaining != 0) begin
            b = it.message_char[7 - st.bit_phase];
            r.pixel_out = (it.pixel_red & LSB_CLEAR) | (b ? LSB_SET : 8'h00);
            st.bit_phase++;
            if (st.bit_phase == 0) begin
              st.chars_remaining--;
              if (st.chars_remaining == 0) st.finished = 1'b1;
            end
          end else begin
            st.finished = 1'b1;
          end
        end
      end else begin
        if (regs.image_pixels == 0) begin
          r.status = 1'b1;
        end else if (in_img && !st.finished) begin
          b = it.pixel_red[0];
          if (st.pixel_index < HDR) begin
            st.header_value = {st.header_value[LEN_W-2:0], b};
            if (st.pixel_index == HDR - 1) begin
              r.length_valid = 1'b1;
              st.chars_remaining = st.header_value;
              st.bit_phase = '0;
              st.char_accum = '0;
              if (st.chars_remaining == 0) st.finished = 1'b1;
            end
          end else if (st.chars_remaining != 0) begin
            st.char_accum = {st.char_accum[BYTE_W-2:0], b};
            st.bit_phase++;
            if (st.bit_phase == 0) begin
              r.char_out = st.char_accum;
              r.char_valid = 1'b1;
              st.char_accum = '0;
              st.chars_remaining--;
              if (st.chars_remaining == 0) st.finished = 1'b1;
            end
          end else begin
            st.finished = 1'b1;
          end
        end
        r.found_length = st.header_value;
      end
      bump_index();
      r.message_done = st.finished;
      expected_q.push_back(r);
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                         result_count, name, got, want));
    endtask

    // Compare one accepted result with the oldest prediction.
    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with no pixel pending", result_count));
      end else begin
        want = expected_q.pop_front();
        compare_field("pixel_out", 32'(got.pixel_out), 32'(want.pixel_out));
        compare_field("char_out", 32'(got.char_out), 32'(want.char_out));
        compare_field("char_valid", 32'(got.char_valid), 32'(want.char_valid));
        compare_field("length_valid", 32'(got.length_valid), 32'(want.length_valid));
        compare_field("found_length", 32'(got.found_length), 32'(want.found_length));
        compare_field("message_done", 32'(got.message_done), 32'(want.message_done));
        compare_field("status", 32'(got.status), 32'(want.status));
      end
      result_count++;
    endtask
  endclass

  logic clk;
  logic rst_n;

  lse_cfg_if cfg_if ();
  lse_in_if  in_if ();
  lse_out_if out_if ();

  lsb_stego_embed_extract #(.HEADER_BITS(HDR)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .in_if  (in_if),
    .out_if (out_if)
  );

  pixel_scoreboard sb = new();

  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_asks = 0;
  int        hold_done = 0;
  int        items_sent;
  int        idle_cycles = 0;
  in_item_t  seen_pixel;
  out_item_t seen_result;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off whenever one is asked for.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_done) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done++;
      end else begin
        out_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Observe every handshake at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.addr, cfg_if.data);
      if (in_if.valid && in_if.ready) begin
        seen_pixel.pixel_red = in_if.pixel_red;
        seen_pixel.message_char = in_if.message_char;
        seen_pixel.first_pixel = in_if.first_pixel;
        sb.note_pixel(seen_pixel);
      end
      if (out_if.valid && out_if.ready) begin
        seen_result.pixel_out = out_if.pixel_out;
        seen_result.char_out = out_if.char_out;
        seen_result.char_valid = out_if.char_valid;
        seen_result.length_valid = out_if.length_valid;
        seen_result.found_length = out_if.found_length;
        seen_result.message_done = out_if.message_done;
        seen_result.status = out_if.status;
        sb.check_result(seen_result);
      end
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready) ||
          (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", idle_cycles);
          $display("lsb_stego_embed_extract test failed");
          $finish;
        end
      end
    end
  end

  // Write one register; called at a falling edge while the block is idle.
  task write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.addr = idx;
    cfg_if.data = data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Mode and length writes carry random junk above the register width.
  task set_mode(input logic mode);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom());
    word[0] = mode;
    write_reg(CFG_EMBED_MODE, word);
  endtask

  task set_length(input logic [LEN_W-1:0] len);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom());
    word[LEN_W-1:0] = len;
    write_reg(CFG_MESSAGE_LENGTH, word);
  endtask

  // Offer one pixel item, with random sender gaps, and wait for acceptance.
  task send_pixel(input logic [7:0] px, input logic [7:0] mc, input logic fp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.pixel_red = px;
    in_if.message_char = mc;
    in_if.first_pixel = fp;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Stop offering pixels and wait until every result has come back.
  task drain_results();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task pick_idling(input int sel);
    case (sel % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  // One embed image: header, message characters held for eight pixels each.
  task embed_image();
    int          len;
    int          npix;
    int          total;
    logic [7:0]  ch;
    len = $urandom_range(0, 5);
    if ($urandom_range(9) == 0) npix = $urandom_range(0, HDR + 8 * len - 1);
    else npix = HDR + 8 * len + $urandom_range(0, 6);
    set_mode(1'b1);
    set_length(LEN_W'(len));
    write_reg(CFG_IMAGE_PIXELS, CFG_DATA_W'(npix));
    total = npix + $urandom_range(1, 3);
    ch = 8'($urandom());
    for (int i = 0; i < total; i++) begin
      if (i >= HDR && (i - HDR) % 8 == 0) ch = 8'($urandom());
      send_pixel(8'($urandom()), (i < HDR) ? 8'($urandom()) : ch, i == 0);
    end
    drain_results();
  endtask

  // One extract image: a header in the low bits, then random character bits.
  task extract_image();
    logic [LEN_W-1:0] hdr;
    logic [7:0]       px;
    int               npix;
    int               total;
    if ($urandom_range(9) == 0) begin
      hdr = LEN_W'($urandom());
      npix = HDR + $urandom_range(0, 30);
    end else begin
      hdr = LEN_W'($urandom_range(0, 5));
      npix = HDR + 8 * int'(hdr) + $urandom_range(0, 6);
    end
    set_mode(1'b0);
    write_reg(CFG_IMAGE_PIXELS, CFG_DATA_W'(npix));
    total = npix + $urandom_range(1, 3);
    for (int i = 0; i < total; i++) begin
      px = 8'($urandom());
      if (i < HDR) px[0] = (HDR - 1 - i < LEN_W) ? hdr[HDR - 1 - i] : 1'b0;
      send_pixel(px, 8'($urandom()), i == 0);
    end
    drain_results();
  endtask

  // Noise: random registers, random pixels, stray image starts, mode changes
  // on a running image.
  task noise_burst();
    int n;
    if ($urandom_range(1)) set_mode(1'($urandom_range(1)));
    if ($urandom_range(1)) begin
      if ($urandom_range(1)) set_length(LEN_W'($urandom_range(0, 6)));
      else set_length(LEN_W'($urandom()));
    end
    case ($urandom_range(3))
      0: write_reg(CFG_IMAGE_PIXELS, '0);
      1: write_reg(CFG_IMAGE_PIXELS, CFG_DATA_W'($urandom()));
      2: write_reg(CFG_IMAGE_PIXELS, CFG_DATA_W'($urandom_range(1, 60)));
      default: ;
    endcase
    n = $urandom_range(10, 40);
    for (int i = 0; i < n; i++)
      send_pixel(8'($urandom()), 8'($urandom()), $urandom_range(9) == 0);
    drain_results();
  endtask

  // Main sequence.
  initial begin
    int seq;
    int pick;
    rst_n = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = '0;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.pixel_red = '0;
    in_if.message_char = '0;
    in_if.first_pixel = 1'b0;
    items_sent = 0;
    pick_idling(0);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset registers: extract mode on an empty image flags an error.
    send_pixel(8'hFF, 8'h00, 1'b1);
    send_pixel(8'h00, 8'hFF, 1'b0);
    drain_results();

    // Embed on an empty image.
    set_mode(1'b1);
    send_pixel(8'hA5, 8'h5A, 1'b1);
    drain_results();

    // Embed into an image one pixel too small for a single character.
    set_length(20'd1);
    write_reg(CFG_IMAGE_PIXELS, 28'd27);
    send_pixel(8'hFF, 8'hFF, 1'b1);
    drain_results();

    // Largest length into the largest image: header bits all ones.
    set_length('1);
    write_reg(CFG_IMAGE_PIXELS, '1);
    send_pixel(8'h00, 8'h00, 1'b1);
    send_pixel(8'hFE, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'h00, 1'b0);
    drain_results();

    // Extract a header of all ones while the receiver holds off for a while.
    set_mode(1'b0);
    hold_asks++;
    for (int i = 0; i < HDR; i++)
      send_pixel((i % 2) ? 8'hFF : 8'h01, 8'h00, i == 0);
    drain_results();

    // Random images and noise under the four idling patterns.
    seq = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick_idling(seq);
      if (seq == 5) hold_asks++;
      pick = $urandom_range(99);
      if (pick < 45) embed_image();
      else if (pick < 85) extract_image();
      else noise_burst();
      seq++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.pending()));
    if (sb.fails == 0) begin
      $display("lsb_stego_embed_extract test passed");
    end else begin
      $display("lsb_stego_embed_extract test failed");
    end
    $finish;
  end

endmodule
